[design/websocket_frame_receiver_assert.svh]
// Assertion macros for the frame receiver modules; wsfr_queue is the one that uses them.
// Both macros expect clk and rst_n to be visible in the module that uses them.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfr assertion failed");

// Next-cycle implication, checked outside reset.
`define WSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfr assertion failed");

`endif

[design/wsfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Seven-bit length codes that announce an extended length, and the largest control-frame length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] CTRL_LEN_MAX = 7'd125;

  // Queue between parser and output stage.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DATA_END = 3'd1,
    EV_PING_END = 3'd2,
    EV_CLOSE    = 3'd3,
    EV_ERROR    = 3'd4
  } ev_t;

  // One classified result as it leaves the parser; the key byte is applied later.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       valid;
    logic       route;
    logic       last;
    logic       bin;
    ev_t        ev;
    logic [6:0] plen;
  } cmd_t;

endpackage

`default_nettype wire

[design/wsfr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfr_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  wire  [7:0]       in_byte,
  output logic             push,
  output wsfr_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    PH_HDR1, PH_HDR2, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_STOPPED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_hdr_r, first_hdr_nxt;
  logic [7:0]  second_hdr_r, second_hdr_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic        msg_bin_r, msg_bin_nxt;
  logic        frag_r, frag_nxt;

  logic        fail, hdr_done, end_now, end_have;
  logic [7:0]  end_data, end_key, kb;
  logic [63:0] rem_dec;
  logic [2:0]  fcnt_inc;
  logic [3:0]  op_in, op_f;

  assign op_in    = in_byte[3:0];
  assign op_f     = first_hdr_r[3:0];
  assign rem_dec  = rem_r - 64'd1;
  assign fcnt_inc = fcnt_r + 3'd1;

  // Key byte for the current payload position; key byte 0 arrived first.
  always_comb begin
    case (mpos_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
    if (!second_hdr_r[7]) begin
      kb = 8'd0;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_hdr_nxt  = first_hdr_r;
    second_hdr_nxt = second_hdr_r;
    fcnt_nxt       = fcnt_r;
    rem_nxt        = rem_r;
    key_nxt        = key_r;
    mpos_nxt       = mpos_r;
    msg_bin_nxt    = msg_bin_r;
    frag_nxt       = frag_r;
    fail           = 1'b0;
    hdr_done       = 1'b0;
    end_now        = 1'b0;
    end_have       = 1'b0;
    end_data       = 8'd0;
    end_key        = 8'd0;
    push           = 1'b0;
    cmd            = '0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HDR1: begin
          first_hdr_nxt = in_byte;
          if (in_byte[6:4] != 3'd0) begin
            fail = 1'b1;
          end else begin
            unique case (op_in) inside
              wsfr_pkg::OP_CONT: begin
                if (!frag_r) fail = 1'b1;
              end
              wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BIN: begin
                if (frag_r) begin
                  fail = 1'b1;
                end else begin
                  msg_bin_nxt = (op_in == wsfr_pkg::OP_BIN);
                  frag_nxt    = !in_byte[7];
                end
              end
              wsfr_pkg::OP_CONN_CLOSE, wsfr_pkg::OP_PING, wsfr_pkg::OP_PONG: begin
                if (!in_byte[7]) fail = 1'b1;
              end
              default: fail = 1'b1;
            endcase
          end
          if (!fail) phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          second_hdr_nxt = in_byte;
          if (first_hdr_r[3] && (in_byte[6:0] > wsfr_pkg::CTRL_LEN_MAX)) begin
            fail = 1'b1;
          end else begin
            fcnt_nxt = 3'd0;
            if (in_byte[6:0] == wsfr_pkg::LEN_EXT16 ||
                in_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
              rem_nxt   = 64'd0;
              phase_nxt = PH_EXTLEN;
            end else begin
              rem_nxt  = {57'd0, in_byte[6:0]};
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          if (second_hdr_r[6:0] == wsfr_pkg::LEN_EXT64 && fcnt_r == 3'd0 && in_byte[7]) begin
            fail = 1'b1;
          end else begin
            rem_nxt  = {rem_r[55:0], in_byte};
            fcnt_nxt = fcnt_inc;
            // The eight-byte count wraps the counter back to zero.
            if (second_hdr_r[6:0] == wsfr_pkg::LEN_EXT16) begin
              hdr_done = (fcnt_inc == 3'd2);
            end else begin
              hdr_done = (fcnt_inc == 3'd0);
            end
          end
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], in_byte};
          fcnt_nxt = fcnt_inc;
          if (fcnt_inc == 3'd4) begin
            fcnt_nxt = 3'd0;
            if (rem_r == 64'd0) begin
              end_now = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_dec;
          if (rem_dec == 64'd0) begin
            end_now  = 1'b1;
            end_have = 1'b1;
            end_data = in_byte;
            end_key  = kb;
          end else begin
            case (op_f) inside
              wsfr_pkg::OP_CONT, wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BIN: begin
                push      = 1'b1;
                cmd.data  = in_byte;
                cmd.key   = kb;
                cmd.valid = 1'b1;
                cmd.bin   = msg_bin_r;
              end
              wsfr_pkg::OP_PING: begin
                push      = 1'b1;
                cmd.data  = in_byte;
                cmd.key   = kb;
                cmd.valid = 1'b1;
                cmd.route = 1'b1;
              end
              default: ;
            endcase
          end
        end
        PH_STOPPED: ;
        default: ;
      endcase

      // Header complete: go to the key, the payload, or end an empty frame.
      if (hdr_done) begin
        fcnt_nxt = 3'd0;
        mpos_nxt = 2'd0;
        key_nxt  = 32'd0;
        if (second_hdr_nxt[7]) begin
          phase_nxt = PH_KEY;
        end else if (rem_nxt == 64'd0) begin
          end_now = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end

      if (end_now) begin
        phase_nxt = PH_HDR1;
        case (op_f) inside
          wsfr_pkg::OP_CONT, wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BIN: begin
            push      = 1'b1;
            cmd.data  = end_data;
            cmd.key   = end_key;
            cmd.valid = end_have;
            cmd.last  = first_hdr_r[7];
            cmd.bin   = msg_bin_r;
            cmd.ev    = wsfr_pkg::EV_DATA_END;
            if (first_hdr_r[7]) begin
              frag_nxt    = 1'b0;
              msg_bin_nxt = 1'b0;
            end
          end
          wsfr_pkg::OP_PING: begin
            push      = 1'b1;
            cmd.data  = end_data;
            cmd.key   = end_key;
            cmd.valid = end_have;
            cmd.route = 1'b1;
            cmd.ev    = wsfr_pkg::EV_PING_END;
            cmd.plen  = second_hdr_nxt[6:0];
          end
          wsfr_pkg::OP_CONN_CLOSE: begin
            phase_nxt = PH_STOPPED;
            push      = 1'b1;
            cmd.ev    = wsfr_pkg::EV_CLOSE;
          end
          default: ;
        endcase
      end

      if (fail) begin
        phase_nxt = PH_STOPPED;
        push      = 1'b1;
        cmd       = '0;
        cmd.ev    = wsfr_pkg::EV_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR1;
      first_hdr_r  <= 8'd0;
      second_hdr_r <= 8'd0;
      fcnt_r       <= 3'd0;
      rem_r        <= 64'd0;
      key_r        <= 32'd0;
      mpos_r       <= 2'd0;
      msg_bin_r    <= 1'b0;
      frag_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      first_hdr_r  <= first_hdr_nxt;
      second_hdr_r <= second_hdr_nxt;
      fcnt_r       <= fcnt_nxt;
      rem_r        <= rem_nxt;
      key_r        <= key_nxt;
      mpos_r       <= mpos_nxt;
      msg_bin_r    <= msg_bin_nxt;
      frag_r       <= frag_nxt;
    end
  end

endmodule

`default_nettype wire

[design/wsfr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_receiver_assert.svh"

module wsfr_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wsfr_pkg::cmd_t   push_cmd,
  output logic             not_full,
  output logic             head_valid,
  output wsfr_pkg::cmd_t   head,
  input  wire              pop
);

  wsfr_pkg::cmd_t          mem_r [wsfr_pkg::QDEPTH];
  logic [wsfr_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [wsfr_pkg::QCW-1:0] cnt_r, cnt_nxt;

  assign not_full   = (cnt_r != wsfr_pkg::QCW'(wsfr_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `WSFR_ASSERT_IMPL(a_no_push_full, push, not_full)
  `WSFR_ASSERT_IMPL(a_no_pop_empty, pop, head_valid)
  `WSFR_ASSERT_NEXT(a_drain_count, pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

`default_nettype wire

[design/wsfr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfr_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              head_valid,
  input  wsfr_pkg::cmd_t   head,
  output logic             pop,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  output logic [4:0]       out_tuser
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        bvalid_r, route_r, last_r, bin_r;
  wsfr_pkg::ev_t ev_r;
  logic [6:0]  plen_r;

  // Load whenever the output register is empty or being drained.
  assign pop = head_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r   <= head.data ^ head.key;
      bvalid_r <= head.valid;
      route_r  <= head.route;
      last_r   <= head.last;
      bin_r    <= head.bin;
      ev_r     <= head.ev;
      plen_r   <= head.plen;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {plen_r, bvalid_r, byte_r};
  assign out_tlast  = last_r;
  assign out_tuser  = {ev_r, bin_r, route_r};

endmodule

`default_nettype wire

[design/websocket_frame_receiver.sv]
// WebSocket frame receiver. The slave stream takes the received byte stream that
// follows the opening handshake, one byte per beat in in_tdata. The master stream
// delivers at most one beat per input byte: unmasked data or ping payload bytes,
// frame-end events, close and protocol-error events. Bytes of pong frames and of
// header fields produce no payload beat.
// Throughput is one byte per clock while the queue has room. The parser decides
// each byte in the cycle it is accepted and writes its result into a four-entry
// queue; an output register behind the queue drives the master side, so a result
// passes through a queue entry and then the output register before it is taken.
// in_tready depends only on the queue fill, so a stalled receiver stops input
// only once the queue and the output register are full; no beat is lost.
// A synchronous active-low reset returns the parser to the first header byte,
// sets the message type to text and empties the queue and output register.
// After a close frame or a protocol error the parser ignores all further bytes
// (they are still accepted) until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_receiver (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [8] payload_valid, [15:9] pong_length
  output logic        out_tlast,  // message_last
  output logic [4:0]  out_tuser   // [0] byte_route, [1] message_is_binary, [4:2] frame_event
);

  logic           in_fire;
  logic           push, pop, head_valid;
  wsfr_pkg::cmd_t push_cmd, head;

  // A beat is taken whenever the queue has room; the parser never stalls itself.
  assign in_fire = in_tvalid && in_tready;

  wsfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .push    (push),
    .cmd     (push_cmd)
  );

  // The queue decouples the parser from the output register so that a stall on
  // the master side reaches in_tready only after the queue has filled up.
  wsfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .not_full   (in_tready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The output stage applies the key byte and holds the beat until it is taken.
  wsfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import wsfr_pkg::*;

  // Stall cycles the watchdog tolerates with no beat accepted on either side.
  localparam int unsigned STALL_LIMIT = 2000;

  // How a frame announces its payload length.
  typedef enum int unsigned {
    LEN_FORM_7,
    LEN_FORM_16,
    LEN_FORM_64
  } len_form_t;

  // Where the decoder stands within the byte stream.
  typedef enum logic [2:0] {
    PARSE_HDR1,
    PARSE_HDR2,
    PARSE_EXTLEN,
    PARSE_KEY,
    PARSE_PAYLOAD,
    PARSE_HALTED
  } parse_phase_t;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       route;
    logic       msg_last;
    logic       is_bin;
    ev_t        ev;
    logic [6:0] pong_len;
  } rx_beat_t;

  // Mirrors the frame decoder byte by byte and holds the beats it still owes.
  class frame_decoder_mirror;
    parse_phase_t phase;
    logic [7:0]   hdr1;
    logic [7:0]   hdr2;
    int unsigned  field_cnt;
    logic [63:0]  remaining;
    logic [31:0]  key;
    logic [1:0]   key_pos;
    logic         msg_bin;
    logic         frag_open;
    rx_beat_t     due_beats[$];
    int unsigned  errors;

    function new();
      phase     = PARSE_HDR1;
      hdr1      = 8'h00;
      hdr2      = 8'h00;
      field_cnt = 0;
      remaining = 64'd0;
      key       = 32'd0;
      key_pos   = 2'd0;
      msg_bin   = 1'b0;
      frag_open = 1'b0;
      errors    = 0;
    endfunction

    function void add_due(logic [7:0] data, logic has_data, logic route, logic msg_last,
                          logic is_bin, ev_t ev, logic [6:0] pong_len);
      rx_beat_t b;
      b.data     = data;
      b.has_data = has_data;
      b.route    = route;
      b.msg_last = msg_last;
      b.is_bin   = is_bin;
      b.ev       = ev;
      b.pong_len = pong_len;
      due_beats.push_back(b);
    endfunction

    // A protocol error reports once and then silences the decoder for good.
    function void halt_error();
      phase = PARSE_HALTED;
      add_due(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, EV_ERROR, 7'd0);
    endfunction

    // Frame end, optionally carrying the last payload byte.
    function void end_frame(logic has_data, logic [7:0] data);
      phase = PARSE_HDR1;
      if (hdr1[3:0] <= OP_BIN) begin
        add_due(data, has_data, 1'b0, hdr1[7], msg_bin, EV_DATA_END, 7'd0);
        if (hdr1[7]) begin
          frag_open = 1'b0;
          msg_bin   = 1'b0;
        end
      end else if (hdr1[3:0] == OP_PING) begin
        add_due(data, has_data, 1'b1, 1'b0, 1'b0, EV_PING_END, hdr2[6:0]);
      end else if (hdr1[3:0] == OP_CONN_CLOSE) begin
        phase = PARSE_HALTED;
        add_due(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, EV_CLOSE, 7'd0);
      end
    endfunction

    // Length is known: go on to the key, the payload, or end an empty frame.
    function void close_header();
      field_cnt = 0;
      key_pos   = 2'd0;
      key       = 32'd0;
      if (hdr2[7]) begin
        phase = PARSE_KEY;
      end else if (remaining == 64'd0) begin
        end_frame(1'b0, 8'h00);
      end else begin
        phase = PARSE_PAYLOAD;
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      logic [3:0]  op;
      logic [6:0]  len7;
      logic [7:0]  kb;
      logic [7:0]  d;
      int unsigned need;
      case (phase)
        PARSE_HDR1: begin
          op   = b[3:0];
          hdr1 = b;
          if (b[6:4] != 3'b000) begin
            halt_error();
          end else if (op == OP_CONT) begin
            if (!frag_open) halt_error();
            else phase = PARSE_HDR2;
          end else if (op == OP_TEXT || op == OP_BIN) begin
            if (frag_open) begin
              halt_error();
            end else begin
              msg_bin   = (op == OP_BIN);
              frag_open = !b[7];
              phase     = PARSE_HDR2;
            end
          end else if (op == OP_CONN_CLOSE || op == OP_PING || op == OP_PONG) begin
            if (!b[7]) halt_error();
            else phase = PARSE_HDR2;
          end else begin
            halt_error();
          end
        end
        PARSE_HDR2: begin
          len7 = b[6:0];
          hdr2 = b;
          if (hdr1[3] && len7 > CTRL_LEN_MAX) begin
            halt_error();
          end else begin
            field_cnt = 0;
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
              remaining = 64'd0;
              phase     = PARSE_EXTLEN;
            end else begin
              remaining = {57'd0, len7};
              close_header();
            end
          end
        end
        PARSE_EXTLEN: begin
          need = (hdr2[6:0] == LEN_EXT16) ? 2 : 8;
          if (need == 8 && field_cnt == 0 && b[7]) begin
            halt_error();
          end else begin
            remaining = {remaining[55:0], b};
            field_cnt++;
            if (field_cnt == need) close_header();
          end
        end
        PARSE_KEY: begin
          key = {key[23:0], b};
          field_cnt++;
          if (field_cnt == 4) begin
            field_cnt = 0;
            if (remaining == 64'd0) end_frame(1'b0, 8'h00);
            else phase = PARSE_PAYLOAD;
          end
        end
        PARSE_PAYLOAD: begin
          // The first key byte received masks payload byte 0.
          kb        = hdr2[7] ? 8'(key >> (24 - 8 * key_pos)) : 8'h00;
          d         = b ^ kb;
          key_pos   = key_pos + 2'd1;
          remaining = remaining - 64'd1;
          if (remaining == 64'd0) begin
            end_frame(1'b1, d);
          end else if (hdr1[3:0] <= OP_BIN) begin
            add_due(d, 1'b1, 1'b0, 1'b0, msg_bin, EV_NONE, 7'd0);
          end else if (hdr1[3:0] == OP_PING) begin
            add_due(d, 1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, 7'd0);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_beat(rx_beat_t got);
      rx_beat_t want;
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat expected none, got %h", $time, got);
      end else begin
        want = due_beats.pop_front();
        compare_field("payload_byte", want.data, got.data);
        compare_field("payload_valid", want.has_data, got.has_data);
        compare_field("byte_route", want.route, got.route);
        compare_field("message_last", want.msg_last, got.msg_last);
        compare_field("message_is_binary", want.is_bin, got.is_bin);
        compare_field("frame_event", int'(want.ev), int'(got.ev));
        compare_field("pong_length", want.pong_len, got.pong_len);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [4:0]  out_tuser;

  frame_decoder_mirror sb;
  int unsigned         rx_items = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         quiet_cycles = 0;

  always #5 clk = ~clk;

  websocket_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result beats are compared in the order they leave the block.
  always @(posedge clk) begin
    rx_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.data     = out_tdata[7:0];
      got.has_data = out_tdata[8];
      got.pong_len = out_tdata[15:9];
      got.msg_last = out_tlast;
      got.route    = out_tuser[0];
      got.is_bin   = out_tuser[1];
      got.ev       = ev_t'(out_tuser[4:2]);
      sb.check_beat(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one byte, idling at random first, and returns at the falling edge
  // after the beat was taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_rx_byte(b);
    rx_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input int unsigned len,
                            input logic masked, input len_form_t form);
    logic [63:0] len64;
    logic [6:0]  len7;
    len64 = len;
    len7  = (form == LEN_FORM_7) ? len64[6:0] : (form == LEN_FORM_16) ? LEN_EXT16 : LEN_EXT64;
    send_byte({fin, 3'b000, op});
    send_byte({masked, len7});
    if (form == LEN_FORM_16) begin
      send_byte(len64[15:8]);
      send_byte(len64[7:0]);
    end
    if (form == LEN_FORM_64)
      for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
    if (masked) repeat (4) send_byte(8'($urandom_range(255)));
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  // Mostly short payloads; now and then an extended length or a long frame.
  task automatic send_data_frame(input logic fin, input logic [3:0] op);
    int unsigned pick;
    int unsigned len;
    len_form_t   form;
    pick = $urandom_range(99);
    if (pick < 60) begin
      form = LEN_FORM_7;
      len  = $urandom_range(12);
    end else if (pick < 70) begin
      form = LEN_FORM_7;
      len  = $urandom_range(125);
    end else if (pick < 85) begin
      form = LEN_FORM_16;
      len  = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(40);
    end else begin
      form = LEN_FORM_64;
      len  = $urandom_range(16);
    end
    send_frame(fin, op, len, 1'($urandom_range(1)), form);
  endtask

  task automatic send_control_frame(input logic [3:0] op);
    int unsigned len;
    if ($urandom_range(9) == 0)
      len = $urandom_range(1) ? int'(CTRL_LEN_MAX) : $urandom_range(125);
    else
      len = $urandom_range(8);
    send_frame(1'b1, op, len, 1'($urandom_range(1)), LEN_FORM_7);
  endtask

  // A whole message, sometimes fragmented, with pings or pongs slipped in
  // between the fragments.
  task automatic send_message();
    int unsigned pieces;
    pieces = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
    send_data_frame(pieces == 0, $urandom_range(1) ? OP_BIN : OP_TEXT);
    for (int i = 1; i <= pieces; i++) begin
      if ($urandom_range(2) == 0) send_control_frame($urandom_range(1) ? OP_PING : OP_PONG);
      send_data_frame(i == pieces, OP_CONT);
    end
  endtask

  task automatic run_traffic(input int unsigned stop_at);
    int unsigned pick;
    while (rx_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) send_message();
      else if (pick < 85) send_control_frame(OP_PING);
      else send_control_frame(OP_PONG);
    end
  endtask

  // Holds the sender off until every owed beat has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.due_beats.size() != 0);
  endtask

  // The stream can end only once per reset, so each run picks at most one way to end it.
  task automatic send_stream_end();
    logic [3:0] ctrl_ops[3];
    ctrl_ops = '{OP_CONN_CLOSE, OP_PING, OP_PONG};
    case ($urandom_range(8))
      0: send_frame(1'b1, OP_CONN_CLOSE, $urandom_range(4), 1'($urandom_range(1)), LEN_FORM_7);
      1: send_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
      2: send_byte({1'($urandom_range(1)), 3'b000,
                    $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15))});
      3: send_byte({1'b1, 3'b000, OP_CONT});
      4: begin
        send_frame(1'b0, OP_TEXT, 1, 1'b0, LEN_FORM_7);
        send_byte({1'b1, 3'b000, $urandom_range(1) ? OP_BIN : OP_TEXT});
      end
      5: send_byte({1'b0, 3'b000, ctrl_ops[$urandom_range(2)]});
      6: begin
        send_byte({1'b1, 3'b000, ctrl_ops[$urandom_range(2)]});
        send_byte({1'($urandom_range(1)), $urandom_range(1) ? LEN_EXT64 : LEN_EXT16});
      end
      7: begin
        send_byte({1'b1, 3'b000, OP_BIN});
        send_byte({1'($urandom_range(1)), LEN_EXT64});
        send_byte(8'h80 | 8'($urandom_range(255)));
      end
      default: ;
    endcase
    // Once stopped, these must all be swallowed without a beat.
    repeat (8) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Slow receiver first.
    send_idle_pct = 8;
    recv_idle_pct = 86;
    send_frame(1'b1, OP_TEXT, 0, 1'b0, LEN_FORM_7);
    send_frame(1'b1, OP_BIN, 0, 1'b1, LEN_FORM_7);
    send_frame(1'b1, OP_PONG, 0, 1'b0, LEN_FORM_7);
    send_frame(1'b0, OP_BIN, 1, 1'b0, LEN_FORM_7);
    send_frame(1'b1, OP_PING, 1, 1'b0, LEN_FORM_7);
    send_frame(1'b1, OP_CONT, 1, 1'b0, LEN_FORM_7);
    send_frame(1'b1, OP_TEXT, 1, 1'b0, LEN_FORM_16);
    run_traffic(650);
    drain();

    // Slow sender.
    send_idle_pct = 86;
    recv_idle_pct = 8;
    run_traffic(1300);
    drain();

    // Full rate both ways.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(1940);
    send_stream_end();

    in_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_beats.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
